// File: hw/rtl/rcd_self_test_sequencer_core_macros.svh
// Assertion macros shared by the self-test sequencer RTL.
// Define ASSERT_OFF to compile every assertion away.
`ifndef RCD_SELF_TEST_SEQUENCER_CORE_MACROS_SVH
`define RCD_SELF_TEST_SEQUENCER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent implies consequent in the same cycle.
`define RCDST_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define RCDST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RCDST_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RCDST_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/rcdst_pkg.sv
// Shared types, codes and constants of the self-test sequencer.
// No dependencies; used by the register file, the step logic, the core and the testbench.
`default_nettype none
package rcdst_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;

	typedef logic [TIMER_BITS-1:0] timer_t;
	typedef logic [3:0]            result_code_t;
	typedef logic [2:0]            phase_t;

	localparam logic [CFG_IDX_W-1:0] REG_STARTUP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ACTIVE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_F6_WAIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_F30_WAIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RECOVERY   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE     = 3'd6;

	localparam timer_t RST_STARTUP    = 16'd300;
	localparam timer_t RST_MIN_ACTIVE = 16'd200;
	localparam timer_t RST_PULSE      = 16'd100;
	localparam timer_t RST_F6_WAIT    = 16'd700;
	localparam timer_t RST_F30_WAIT   = 16'd700;
	localparam timer_t RST_RECOVERY   = 16'd2500;
	localparam timer_t RST_SETTLE     = 16'd100;

	localparam phase_t PH_IDLE     = 3'd0;
	localparam phase_t PH_STARTUP  = 3'd1;
	localparam phase_t PH_PULSE    = 3'd2;
	localparam phase_t PH_WAIT_F6  = 3'd3;
	localparam phase_t PH_WAIT_F30 = 3'd4;
	localparam phase_t PH_RECOVERY = 3'd5;
	localparam phase_t PH_SETTLE   = 3'd6;
	localparam phase_t PH_HOLD     = 3'd7;

	localparam result_code_t RES_IDLE    = 4'd0;
	localparam result_code_t RES_RUNNING = 4'd1;
	localparam result_code_t RES_PASS    = 4'd2;
	localparam result_code_t RES_INITIAL = 4'd3;
	localparam result_code_t RES_F6_TO   = 4'd4;
	localparam result_code_t RES_F30_TO  = 4'd5;
	localparam result_code_t RES_REC_TO  = 4'd6;
	localparam result_code_t RES_SENSOR  = 4'd7;
	localparam result_code_t RES_SEQ     = 4'd8;

	typedef struct packed {
		timer_t startup_ms;
		timer_t min_active_ms;
		timer_t pulse_ms;
		timer_t f6_wait_ms;
		timer_t f30_wait_ms;
		timer_t recovery_ms;
		timer_t settle_ms;
	} cfg_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] cmd_len;
		logic [7:0] cmd_value;
		logic       f6_level;
		logic       f30_level;
		logic       err_level;
	} item_t;

	typedef struct packed {
		logic         test_pin;
		logic         test_busy;
		result_code_t test_result;
		logic         cmd_accepted;
	} result_t;

	// Saturating increment of a timer.
	function automatic timer_t tinc(input timer_t v);
		return (v == {TIMER_BITS{1'b1}}) ? v : v + timer_t'(1);
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/rcdst_if.sv
// Handshake channels of the self-test sequencer: command items in, results out.
// Depends on nothing but plain logic types.
`default_nettype none
interface rcdst_item_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] cmd_len;
	logic [7:0] cmd_value;
	logic       f6_level;
	logic       f30_level;
	logic       err_level;

	modport source (output valid, cmd, cmd_len, cmd_value, f6_level, f30_level, err_level,
		input ready);
	modport sink (input valid, cmd, cmd_len, cmd_value, f6_level, f30_level, err_level,
		output ready);
endinterface

interface rcdst_result_if;
	logic       valid;
	logic       ready;
	logic       test_pin;
	logic       test_busy;
	logic [3:0] test_result;
	logic       cmd_accepted;

	modport source (output valid, test_pin, test_busy, test_result, cmd_accepted,
		input ready);
	modport sink (input valid, test_pin, test_busy, test_result, cmd_accepted,
		output ready);
endinterface
`default_nettype wire

// File: hw/rtl/rcdst_cfg_regs.sv
// Configuration register file of the self-test sequencer.
// Depends on rcdst_pkg for the register indexes and reset values.
`default_nettype none
module rcdst_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rcdst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rcdst_pkg::CFG_W-1:0]     cfg_wdata,
	output rcdst_pkg::cfg_t                     cfg
);
	import rcdst_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.startup_ms    <= RST_STARTUP;
			cfg_q.min_active_ms <= RST_MIN_ACTIVE;
			cfg_q.pulse_ms      <= RST_PULSE;
			cfg_q.f6_wait_ms    <= RST_F6_WAIT;
			cfg_q.f30_wait_ms   <= RST_F30_WAIT;
			cfg_q.recovery_ms   <= RST_RECOVERY;
			cfg_q.settle_ms     <= RST_SETTLE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STARTUP:    cfg_q.startup_ms    <= cfg_wdata;
				REG_MIN_ACTIVE: cfg_q.min_active_ms <= cfg_wdata;
				REG_PULSE:      cfg_q.pulse_ms      <= cfg_wdata;
				REG_F6_WAIT:    cfg_q.f6_wait_ms    <= cfg_wdata;
				REG_F30_WAIT:   cfg_q.f30_wait_ms   <= cfg_wdata;
				REG_RECOVERY:   cfg_q.recovery_ms   <= cfg_wdata;
				REG_SETTLE:     cfg_q.settle_ms     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule
`default_nettype wire

// File: hw/rtl/rcdst_step.sv
// Sequencer state and the per-tick next-state logic of the self-test.
// Depends on rcdst_pkg for phase and result codes, types and tinc().
`default_nettype none
module rcdst_step (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  rcdst_pkg::item_t item,
	input  rcdst_pkg::cfg_t  cfg,
	output rcdst_pkg::result_t res
);
	import rcdst_pkg::*;

	phase_t       phase_q, ph_cur, ph_n;
	timer_t       ptim_q, ptim_n;
	timer_t       atim_q, atim_n;
	timer_t       uptime_q, uptime_n;
	logic         early_q, early_n;
	logic         active_q, act_n;
	result_code_t last_q, last_n;
	result_code_t pend_q, pend_n;
	logic         acc;

	always_comb begin
		acc = item.cmd && (item.cmd_len == 8'd1) && (item.cmd_value == 8'd1) && !active_q;

		act_n   = active_q;
		last_n  = last_q;
		atim_n  = atim_q;
		ptim_n  = ptim_q;
		early_n = early_q;
		pend_n  = pend_q;
		ph_cur  = phase_q;
		if (acc) begin
			act_n   = 1'b1;
			last_n  = RES_RUNNING;
			atim_n  = '0;
			ptim_n  = '0;
			early_n = 1'b0;
			ph_cur  = PH_STARTUP;
		end
		ph_n = ph_cur;

		case (ph_cur)
			PH_STARTUP: begin
				if (uptime_q >= cfg.startup_ms) begin
					if (item.f6_level || item.f30_level) begin
						pend_n = RES_INITIAL;
						ph_n   = PH_HOLD;
					end else begin
						ph_n   = PH_PULSE;
						ptim_n = '0;
					end
				end
			end
			PH_PULSE: begin
				// The pulse counts first, so a limit of zero still gives one low tick.
				ptim_n = tinc(ptim_n);
				if (ptim_n >= cfg.pulse_ms) begin
					ph_n    = PH_WAIT_F6;
					ptim_n  = '0;
					early_n = 1'b0;
				end
			end
			PH_WAIT_F6: begin
				if (item.f30_level)
					early_n = 1'b1;
				if (item.f6_level) begin
					if (early_n) begin
						pend_n = RES_SEQ;
						ph_n   = PH_HOLD;
					end else begin
						ph_n   = PH_WAIT_F30;
						ptim_n = '0;
					end
				end else if (ptim_n >= cfg.f6_wait_ms) begin
					pend_n = RES_F6_TO;
					ph_n   = PH_HOLD;
				end else begin
					ptim_n = tinc(ptim_n);
				end
			end
			PH_WAIT_F30: begin
				if (item.f30_level) begin
					ph_n   = PH_RECOVERY;
					ptim_n = '0;
				end else if (ptim_n >= cfg.f30_wait_ms) begin
					pend_n = RES_F30_TO;
					ph_n   = PH_HOLD;
				end else begin
					ptim_n = tinc(ptim_n);
				end
			end
			PH_RECOVERY: begin
				if (!item.f6_level && !item.f30_level) begin
					ph_n   = PH_SETTLE;
					ptim_n = '0;
				end else if (ptim_n >= cfg.recovery_ms) begin
					pend_n = RES_REC_TO;
					ph_n   = PH_HOLD;
				end else begin
					ptim_n = tinc(ptim_n);
				end
			end
			PH_SETTLE: begin
				if (ptim_n >= cfg.settle_ms) begin
					pend_n = item.err_level ? RES_SENSOR : RES_PASS;
					ph_n   = PH_HOLD;
				end else begin
					ptim_n = tinc(ptim_n);
				end
			end
			default: ;
		endcase

		// A finished test is released once it has been active long enough.
		if ((ph_n == PH_HOLD) && (atim_n >= cfg.min_active_ms)) begin
			act_n  = 1'b0;
			last_n = pend_n;
			ph_n   = PH_IDLE;
		end

		res.test_pin     = (ph_n != PH_PULSE);
		res.test_busy    = act_n;
		res.test_result  = act_n ? RES_RUNNING : last_n;
		res.cmd_accepted = acc;

		if (act_n)
			atim_n = tinc(atim_n);
		uptime_n = (uptime_q < cfg.startup_ms) ? tinc(uptime_q) : uptime_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			ptim_q   <= '0;
			atim_q   <= '0;
			uptime_q <= '0;
			early_q  <= 1'b0;
			active_q <= 1'b0;
			last_q   <= RES_IDLE;
			pend_q   <= RES_IDLE;
		end else if (en) begin
			phase_q  <= ph_n;
			ptim_q   <= ptim_n;
			atim_q   <= atim_n;
			uptime_q <= uptime_n;
			early_q  <= early_n;
			active_q <= act_n;
			last_q   <= last_n;
			pend_q   <= pend_n;
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/rcd_self_test_sequencer_core.sv
// Residual-current sensor self-test sequencer. Each input transaction is one
// millisecond tick carrying the sampled trip and error pins and, optionally, a test
// command; each produces exactly one result transaction with the test pin drive,
// the busy flag, the result code and whether this tick's command started a test.
// The block takes one transaction per clock cycle while the result side keeps up;
// an accepted transaction is held in the input register, the whole tick is evaluated
// between the input register and the result register, and the result is offered
// from the result register until it is taken.
// A result left waiting holds the input register, after which the input stalls.
// Configuration registers hold their documented reset values and may be written
// only while no transaction is in flight.
// Depends on rcdst_pkg, rcdst_if, rcdst_cfg_regs, rcdst_step and the macros header.
`default_nettype none
`include "rcd_self_test_sequencer_core_macros.svh"
module rcd_self_test_sequencer_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [rcdst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [rcdst_pkg::CFG_W-1:0]     cfg_wdata,
	rcdst_item_if.sink                           item,
	rcdst_result_if.source                       result
);
	import rcdst_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_s2;
	logic    valid_s2;
	logic    item_acc;
	logic    advance;

	// The input stage moves on whenever the result register is free or being drained.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign item_acc   = item.valid && item.ready;

	rcdst_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	rcdst_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_s1.cmd       <= item.cmd;
			item_s1.cmd_len   <= item.cmd_len;
			item_s1.cmd_value <= item.cmd_value;
			item_s1.f6_level  <= item.f6_level;
			item_s1.f30_level <= item.f30_level;
			item_s1.err_level <= item.err_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res_comb;
	end

	assign result.valid        = valid_s2;
	assign result.test_pin     = res_s2.test_pin;
	assign result.test_busy    = res_s2.test_busy;
	assign result.test_result  = res_s2.test_result;
	assign result.cmd_accepted = res_s2.cmd_accepted;

	`RCDST_ASSERT_NEXT(a_advance_fills_result, clk, arst_n, advance, valid_s2)
	`RCDST_ASSERT_IMPL(a_pulse_only_when_busy, clk, arst_n, valid_s2,
		res_s2.test_pin || res_s2.test_busy)
	`RCDST_ASSERT_IMPL(a_busy_reports_running, clk, arst_n,
		valid_s2 && res_s2.test_busy, res_s2.test_result == RES_RUNNING)
	`RCDST_ASSERT_IMPL(a_running_code_only_busy, clk, arst_n,
		valid_s2 && !res_s2.test_busy, res_s2.test_result != RES_RUNNING)
endmodule
`default_nettype wire

// File: verif/rcd_self_test_sequencer_core_tb.sv
// Self-checking testbench of the residual-current self-test sequencer core.
// Drives millisecond ticks through the item channel, predicts every result transaction
// with a cycle-free model of the sequence, and depends on rcdst_pkg, rcdst_if and the RTL.
module rcd_self_test_sequencer_core_tb;
	import rcdst_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	rcdst_item_if item_ch ();
	rcdst_result_if res_ch ();

	rcd_self_test_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (res_ch)
	);

	initial forever #2 clk = ~clk;

	// Stimulus and expectation stores.
	item_t   pending_ticks [$];
	result_t result_store [$];
	int unsigned ticks_queued = 0;
	int unsigned ticks_handed = 0;
	int unsigned ticks_taken = 0;
	int unsigned results_checked = 0;
	int unsigned failures = 0;
	int unsigned send_gap = 0;
	int unsigned take_gap = 0;
	int unsigned hold_left = 0;
	int unsigned stalls_asked = 0;
	int unsigned stalls_served = 0;
	int unsigned settings_used = 0;
	bit idle_on = 1'b0;

	// Shadow of the sequencer.
	cfg_t         cfg_shadow;
	phase_t       seq_phase;
	timer_t       phase_ticks;
	timer_t       active_ticks;
	timer_t       uptime_ticks;
	logic         early_f30;
	logic         test_running;
	result_code_t last_code;
	result_code_t held_code;
	int unsigned  tests_started;
	int unsigned  tests_passed;
	int unsigned  tests_faulted;

	function automatic timer_t bump(input timer_t v);
		return (&v) ? v : v + timer_t'(1);
	endfunction

	task automatic conclude(input result_code_t code);
		held_code = code;
		seq_phase = PH_HOLD;
	endtask

	task automatic apply_write(input logic [CFG_IDX_W-1:0] idx, input timer_t v);
		case (idx)
		REG_STARTUP:    cfg_shadow.startup_ms = v;
		REG_MIN_ACTIVE: cfg_shadow.min_active_ms = v;
		REG_PULSE:      cfg_shadow.pulse_ms = v;
		REG_F6_WAIT:    cfg_shadow.f6_wait_ms = v;
		REG_F30_WAIT:   cfg_shadow.f30_wait_ms = v;
		REG_RECOVERY:   cfg_shadow.recovery_ms = v;
		REG_SETTLE:     cfg_shadow.settle_ms = v;
		default: ;
		endcase
	endtask

	// One millisecond tick of the sequence; a command is handled before the tick itself.
	task automatic advance_sequence(input item_t it, output result_t r);
		logic started;
		started = 1'b0;
		if (it.cmd && it.cmd_len == 8'd1 && it.cmd_value == 8'd1 && !test_running) begin
			started = 1'b1;
			test_running = 1'b1;
			last_code = RES_RUNNING;
			active_ticks = '0;
			phase_ticks = '0;
			early_f30 = 1'b0;
			seq_phase = PH_STARTUP;
			tests_started++;
		end
		case (seq_phase)
		PH_STARTUP: begin
			if (uptime_ticks >= cfg_shadow.startup_ms) begin
				if (it.f6_level || it.f30_level) begin
					conclude(RES_INITIAL);
				end else begin
					seq_phase = PH_PULSE;
					phase_ticks = '0;
				end
			end
		end
		PH_PULSE: begin
			phase_ticks = bump(phase_ticks);
			if (phase_ticks >= cfg_shadow.pulse_ms) begin
				seq_phase = PH_WAIT_F6;
				phase_ticks = '0;
				early_f30 = 1'b0;
			end
		end
		PH_WAIT_F6: begin
			if (it.f30_level)
				early_f30 = 1'b1;
			if (it.f6_level) begin
				if (early_f30) begin
					conclude(RES_SEQ);
				end else begin
					seq_phase = PH_WAIT_F30;
					phase_ticks = '0;
				end
			end else if (phase_ticks >= cfg_shadow.f6_wait_ms) begin
				conclude(RES_F6_TO);
			end else begin
				phase_ticks = bump(phase_ticks);
			end
		end
		PH_WAIT_F30: begin
			if (it.f30_level) begin
				seq_phase = PH_RECOVERY;
				phase_ticks = '0;
			end else if (phase_ticks >= cfg_shadow.f30_wait_ms) begin
				conclude(RES_F30_TO);
			end else begin
				phase_ticks = bump(phase_ticks);
			end
		end
		PH_RECOVERY: begin
			if (!it.f6_level && !it.f30_level) begin
				seq_phase = PH_SETTLE;
				phase_ticks = '0;
			end else if (phase_ticks >= cfg_shadow.recovery_ms) begin
				conclude(RES_REC_TO);
			end else begin
				phase_ticks = bump(phase_ticks);
			end
		end
		PH_SETTLE: begin
			if (phase_ticks >= cfg_shadow.settle_ms)
				conclude(it.err_level ? RES_SENSOR : RES_PASS);
			else
				phase_ticks = bump(phase_ticks);
		end
		default: ;
		endcase
		// The test is only released once it has been reported active for long enough.
		if (seq_phase == PH_HOLD && active_ticks >= cfg_shadow.min_active_ms) begin
			test_running = 1'b0;
			last_code = held_code;
			seq_phase = PH_IDLE;
			if (held_code == RES_PASS)
				tests_passed++;
			else
				tests_faulted++;
		end
		r.test_pin = (seq_phase != PH_PULSE);
		r.test_busy = test_running;
		r.test_result = test_running ? RES_RUNNING : last_code;
		r.cmd_accepted = started;
		if (test_running)
			active_ticks = bump(active_ticks);
		if (uptime_ticks < cfg_shadow.startup_ms)
			uptime_ticks = bump(uptime_ticks);
	endtask

	// Prediction and checking share one process so that pushes and pops never race.
	always @(posedge clk or negedge arst_n) begin
		item_t   seen;
		result_t want;
		result_t got;
		if (!arst_n) begin
			cfg_shadow.startup_ms <= RST_STARTUP;
			cfg_shadow.min_active_ms <= RST_MIN_ACTIVE;
			cfg_shadow.pulse_ms <= RST_PULSE;
			cfg_shadow.f6_wait_ms <= RST_F6_WAIT;
			cfg_shadow.f30_wait_ms <= RST_F30_WAIT;
			cfg_shadow.recovery_ms <= RST_RECOVERY;
			cfg_shadow.settle_ms <= RST_SETTLE;
			seq_phase <= PH_IDLE;
			phase_ticks <= '0;
			active_ticks <= '0;
			uptime_ticks <= '0;
			early_f30 <= 1'b0;
			test_running <= 1'b0;
			last_code <= RES_IDLE;
			held_code <= RES_IDLE;
			tests_started <= 0;
			tests_passed <= 0;
			tests_faulted <= 0;
		end else begin
			if (cfg_we)
				apply_write(cfg_index, cfg_wdata);
			if (item_ch.valid && item_ch.ready) begin
				seen.cmd = item_ch.cmd;
				seen.cmd_len = item_ch.cmd_len;
				seen.cmd_value = item_ch.cmd_value;
				seen.f6_level = item_ch.f6_level;
				seen.f30_level = item_ch.f30_level;
				seen.err_level = item_ch.err_level;
				advance_sequence(seen, want);
				result_store.push_back(want);
				ticks_taken++;
			end
			if (res_ch.valid && res_ch.ready) begin
				got.test_pin = res_ch.test_pin;
				got.test_busy = res_ch.test_busy;
				got.test_result = res_ch.test_result;
				got.cmd_accepted = res_ch.cmd_accepted;
				if (result_store.size() == 0) begin
					failures++;
					$display("%0t: unexpected result transaction", $time,
						" pin=%0b busy=%0b code=%0d acc=%0b", got.test_pin,
						got.test_busy, got.test_result, got.cmd_accepted);
				end else begin
					want = result_store.pop_front();
					results_checked++;
					if (got !== want) begin
						failures++;
						$display("%0t: mismatch, expected pin=%0b busy=%0b code=%0d acc=%0b",
							$time, want.test_pin, want.test_busy, want.test_result,
							want.cmd_accepted, ", got pin=%0b busy=%0b code=%0d acc=%0b",
							got.test_pin, got.test_busy, got.test_result,
							got.cmd_accepted);
					end
				end
			end
		end
	end

	// Sender: one transaction on the bus at a time, with random gaps between them.
	always @(negedge clk) begin
		item_t nxt;
		if (arst_n && ticks_handed == ticks_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				item_ch.valid <= 1'b0;
			end else if (pending_ticks.size() > 0) begin
				nxt = pending_ticks.pop_front();
				item_ch.cmd <= nxt.cmd;
				item_ch.cmd_len <= nxt.cmd_len;
				item_ch.cmd_value <= nxt.cmd_value;
				item_ch.f6_level <= nxt.f6_level;
				item_ch.f30_level <= nxt.f30_level;
				item_ch.err_level <= nxt.err_level;
				item_ch.valid <= 1'b1;
				ticks_handed++;
				if (idle_on && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 10);
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall bursts, plus a long hold-off whenever one is requested.
	always @(negedge clk) begin
		if (stalls_served != stalls_asked) begin
			stalls_served++;
			hold_left = 60;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else if (take_gap > 0) begin
			take_gap--;
			res_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			take_gap = $urandom_range(0, 9);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	task automatic queue_tick(input logic c, input logic [7:0] len, input logic [7:0] val,
		input logic f6, input logic f30, input logic err);
		item_t it;
		it.cmd = c;
		it.cmd_len = len;
		it.cmd_value = val;
		it.f6_level = f6;
		it.f30_level = f30;
		it.err_level = err;
		pending_ticks.push_back(it);
		ticks_queued++;
	endtask

	task automatic queue_noise();
		logic [7:0] len;
		logic [7:0] val;
		len = 8'($urandom_range(0, 255));
		val = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 3) == 0) begin
			len = 8'd1;
			val = ($urandom_range(0, 1) == 0) ? 8'd1 : val;
		end
		queue_tick(1'($urandom_range(0, 1)), len, val, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// A plausible sensor response: start, quiet, 6 mA, then 30 mA, then both clear.
	task automatic queue_test_run();
		int unsigned n;
		logic err;
		logic trip_at_start;
		trip_at_start = ($urandom_range(0, 11) == 0);
		err = ($urandom_range(0, 3) == 0);
		queue_tick(1'b1, 8'd1, 8'd1, trip_at_start, trip_at_start && $urandom_range(0, 1),
			1'($urandom_range(0, 1)));
		n = $urandom_range(0, 10);
		repeat (n)
			queue_tick(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				trip_at_start, 1'b0, 1'($urandom_range(0, 1)));
		if ($urandom_range(0, 6) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n)
				queue_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0);
		end
		n = $urandom_range(0, 7);
		repeat (n)
			queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
		n = $urandom_range(0, 7);
		repeat (n)
			queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0);
		n = $urandom_range(1, 14);
		repeat (n)
			queue_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b0, err);
	endtask

	task automatic queue_phase(input int unsigned count);
		int unsigned stop_at;
		stop_at = ticks_queued + count;
		while (ticks_queued < stop_at) begin
			if ($urandom_range(0, 4) == 0)
				queue_noise();
			else
				queue_test_run();
		end
	endtask

	// Returns once every tick has been taken and every result has come back.
	task automatic wait_quiet();
		while (pending_ticks.size() != 0 || ticks_handed != ticks_taken ||
			result_store.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input timer_t v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_regs(input cfg_t c);
		write_reg(REG_STARTUP, c.startup_ms);
		write_reg(REG_MIN_ACTIVE, c.min_active_ms);
		write_reg(REG_PULSE, c.pulse_ms);
		write_reg(REG_F6_WAIT, c.f6_wait_ms);
		write_reg(REG_F30_WAIT, c.f30_wait_ms);
		write_reg(REG_RECOVERY, c.recovery_ms);
		write_reg(REG_SETTLE, c.settle_ms);
		settings_used++;
	endtask

	// Mostly short limits so that whole sequences fit in a phase, now and then an extreme.
	function automatic timer_t pick_limit();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return timer_t'($urandom_range(0, 6));
		else if (roll < 78)
			return timer_t'($urandom_range(7, 40));
		else if (roll < 90)
			return '0;
		else if (roll < 94)
			return '1;
		else
			return timer_t'($urandom_range(0, 65535));
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		c.startup_ms = pick_limit();
		c.min_active_ms = pick_limit();
		c.pulse_ms = pick_limit();
		c.f6_wait_ms = pick_limit();
		c.f30_wait_ms = pick_limit();
		c.recovery_ms = pick_limit();
		c.settle_ms = pick_limit();
		return c;
	endfunction

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_STARTUP;
		cfg_wdata = '0;
		item_ch.valid = 1'b0;
		item_ch.cmd = 1'b0;
		item_ch.cmd_len = '0;
		item_ch.cmd_value = '0;
		item_ch.f6_level = 1'b0;
		item_ch.f30_level = 1'b0;
		item_ch.err_level = 1'b0;
		res_ch.ready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		idle_on = 1'b1;

		// Malformed commands are ignored; a good one starts a test in its startup wait.
		queue_tick(1'b1, 8'd0, 8'd1, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b1, 8'd1, 8'd0, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
		queue_tick(1'b1, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0);
		wait_quiet();

		// All limits at zero, and a write to the unused index that must change nothing.
		c = '0;
		program_regs(c);
		write_reg(REG_UNUSED, '1);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);   // trip already asserted
		queue_tick(1'b1, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b1, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0);   // command while running
		queue_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);   // 6 mA never comes
		queue_tick(1'b1, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0);   // 30 mA seen with 6 mA
		queue_tick(1'b1, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);   // 30 mA never comes
		queue_tick(1'b1, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);   // trips do not clear
		queue_tick(1'b1, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		queue_tick(1'b0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);   // error pin still high
		wait_quiet();

		// Every limit at its maximum: the test started here stays in its startup wait.
		c = '1;
		program_regs(c);
		queue_tick(1'b1, 8'd1, 8'd1, 1'b0, 1'b0, 1'b0);
		repeat (30)
			queue_noise();
		wait_quiet();

		for (int phase_no = 0; phase_no < 13; phase_no++) begin
			idle_on = (phase_no == 12) ? 1'b0 : ($urandom_range(0, 3) != 0);
			program_regs(random_cfg());
			queue_phase(125);
			// Hold results back while the sender keeps offering, so the input stalls.
			if (phase_no == 2 || phase_no == 8)
				stalls_asked++;
			// Pause the sender midway until the block has drained.
			if (phase_no == 5) begin
				wait_quiet();
				queue_phase(20);
			end
			wait_quiet();
		end

		repeat (8) @(posedge clk);
		$display("%0d ticks checked under %0d register settings", results_checked,
			settings_used);
		$display("%0d tests started, %0d passed, %0d ended in a fault", tests_started,
			tests_passed, tests_faulted);
		if (failures == 0)
			$display("rcd_self_test_sequencer_core_tb: clean");
		else
			$display("rcd_self_test_sequencer_core_tb: errors");
		$finish;
	end

	initial begin
		#1600000;
		$display("timed out with %0d results outstanding", result_store.size());
		$display("rcd_self_test_sequencer_core_tb: errors");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/rcdst_pkg.sv
hw/rtl/rcdst_if.sv
hw/rtl/rcdst_cfg_regs.sv
hw/rtl/rcdst_step.sv
hw/rtl/rcd_self_test_sequencer_core.sv
verif/rcd_self_test_sequencer_core_tb.sv
